### hw/rtl/text_console_cell_writer_defines.svh
// ----------------------------------------------------------------------------
// text_console_cell_writer_defines.svh
// Assertion macros shared by the console writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
// expr must hold at every edge out of reset
`define TCW_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("tcw assertion failed");
// same-cycle implication
`define TCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcw assertion failed");
// next-cycle implication
`define TCW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcw assertion failed");
`else
`define TCW_ASSERT(lbl, expr)
`define TCW_ASSERT_IMP(lbl, ante, cons)
`define TCW_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Constants, codes, types and helpers for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned COL_W      = 7;
  localparam int unsigned ROW_W      = 5;
  localparam int unsigned IDX_W      = 11;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned NUM_W      = 32;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned CLR_W      = 4;
  localparam int unsigned ENTRY_W    = 16;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned CNT_W      = 4;   // holds BCD_DIGITS
  localparam int unsigned STEP_W     = 6;   // holds NUM_W
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = CLR_W;

  // operation codes
  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_DEC    = 2'd1;
  localparam logic [1:0] OP_HEX    = 2'd2;
  localparam logic [1:0] OP_SETCUR = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

  // reset colours
  localparam logic [CLR_W-1:0] FG_RESET = 4'hF;
  localparam logic [CLR_W-1:0] BG_RESET = 4'h0;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_X       = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_A       = 8'h41;

  // cursor update request
  typedef struct packed {
    logic              put;      // cell written, advance with wrap
    logic              newline;  // column 0, next row
    logic              set;      // move if on screen
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
  } cur_cmd_t;

  // cursor status: position after the request, cell of the position before
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [IDX_W-1:0] idx;
  } cur_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'b0, d};
    end
    return CHAR_A + {4'b0, d} - 8'd10;
  endfunction

endpackage

### hw/rtl/tcw_in_if.sv
// ----------------------------------------------------------------------------
// tcw_in_if
// Command channel: valid/ready with operation and operands.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [CHAR_W-1:0] char_code;
  logic [NUM_W-1:0]  number;
  logic [POS_W-1:0]  new_col;
  logic [POS_W-1:0]  new_row;

  modport source(output valid, operation, char_code, number, new_col, new_row,
                 input ready);
  modport sink(input valid, operation, char_code, number, new_col, new_row,
               output ready);
endinterface

### hw/rtl/tcw_out_if.sv
// ----------------------------------------------------------------------------
// tcw_out_if
// Result channel: valid/ready with one cell write or cursor report.
// ----------------------------------------------------------------------------
interface tcw_out_if;
  import tcw_pkg::*;

  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [IDX_W-1:0]   cell_index;
  logic [ENTRY_W-1:0] cell_entry;
  logic [COL_W-1:0]   cursor_col_now;
  logic [ROW_W-1:0]   cursor_row_now;
  logic               last;

  modport source(output valid, write_enable, cell_index, cell_entry,
                 cursor_col_now, cursor_row_now, last, input ready);
  modport sink(input valid, write_enable, cell_index, cell_entry,
               cursor_col_now, cursor_row_now, last, output ready);
endinterface

### hw/rtl/text_console_cell_writer.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text-mode console writer: cursor tracking and cell writes for characters,
// decimal and hex numbers, and cursor moves.
// ----------------------------------------------------------------------------
// One command word is taken at a time; in_ch.ready is high only while the
// writer is idle. Results leave at most one per cycle while the sink is ready,
// from an output register, so a stalled sink only holds the writer, never
// drops a word. Put character and set cursor are accepted, then emit one
// result. Hex emits '0', 'x' and eight digits, most significant first.
// Decimal runs the number through the bit-serial binary-to-BCD converter, 32
// shift steps, then walks the ten BCD digits from the top, skipping each
// leading zero and emitting each digit after it. Zero prints a single '0'. A
// newline character moves the cursor without writing; the row wraps to 0,
// there is no scrolling. Colours are written through the cfg port (index 0
// foreground, 1 background) by the user, only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_defines.svh"

module text_console_cell_writer (
  input  logic                             clk,
  input  logic                             rst_n,
  tcw_in_if.sink                           in_ch,
  tcw_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tcw_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;  // BCD converter running
  localparam logic [1:0] S_EMIT = 2'd2;  // at most one result per cycle, while the sink is ready

  logic [1:0]        state_r;
  logic [1:0]        op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [POS_W-1:0]  nc_r, nr_r;
  logic [BCD_W-1:0]  dig_r;              // digit shifter, top nibble next
  logic [CNT_W-1:0]  cnt_r;              // results (or digits) left
  logic              started_r;          // a nonzero decimal digit was seen
  logic [CLR_W-1:0]  fg_r, bg_r;

  // output register
  logic               out_valid_r;
  logic               out_we_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [ENTRY_W-1:0] out_entry_r;
  logic [COL_W-1:0]   out_col_r;
  logic [ROW_W-1:0]   out_row_r;
  logic               out_last_r;

  logic              accept, conv_start, conv_done;
  logic [BCD_W-1:0]  conv_bcd;
  logic [3:0]        top_dig;
  logic              skip, fire, shift_dig;
  logic [CHAR_W-1:0] emit_char;
  cur_cmd_t          cmd;
  cur_stat_t         stat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign conv_start  = accept && (in_ch.operation == OP_DEC);
  assign top_dig     = dig_r[BCD_W-1 -: 4];

  tcw_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .value (in_ch.number),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // leading zeros of a decimal are dropped, but the units digit always goes
  assign skip = (state_r == S_EMIT) && (op_r == OP_DEC) && !started_r &&
                (top_dig == 4'd0) && (cnt_r != CNT_W'(1));
  assign fire = (state_r == S_EMIT) && !skip && (!out_valid_r || out_ch.ready);

  // hex prefix occupies the first two results and does not consume a digit
  assign shift_dig = !((op_r == OP_HEX) && (cnt_r >= CNT_W'(BCD_DIGITS - 1)));

  always_comb begin
    case (op_r)
      OP_PUT:  emit_char = ch_r;
      OP_HEX: begin
        if (cnt_r == CNT_W'(BCD_DIGITS)) begin
          emit_char = CHAR_ZERO;
        end else if (cnt_r == CNT_W'(BCD_DIGITS - 1)) begin
          emit_char = CHAR_X;
        end else begin
          emit_char = digit_char(top_dig);
        end
      end
      OP_DEC:  emit_char = digit_char(top_dig);
      default: emit_char = '0;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.col     = nc_r;
    cmd.row     = nr_r;
    if (fire) begin
      if (op_r == OP_SETCUR) begin
        cmd.set = 1'b1;
      end else if (emit_char == CHAR_NEWLINE) begin
        cmd.newline = 1'b1;
      end else begin
        cmd.put = 1'b1;
      end
    end
  end

  tcw_cursor u_cursor (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      started_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            started_r <= 1'b0;
            case (in_ch.operation)
              OP_DEC: begin
                cnt_r   <= CNT_W'(BCD_DIGITS);
                state_r <= S_CONV;
              end
              OP_HEX: begin
                cnt_r   <= CNT_W'(BCD_DIGITS);
                state_r <= S_EMIT;
              end
              default: begin
                cnt_r   <= CNT_W'(1);
                state_r <= S_EMIT;
              end
            endcase
          end
        end
        S_CONV: begin
          if (conv_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (skip) begin
            cnt_r <= cnt_r - 1'b1;
          end else if (fire) begin
            cnt_r     <= cnt_r - 1'b1;
            started_r <= 1'b1;
            if (cnt_r == CNT_W'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // operands and digit shifter
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_ch.operation;
      ch_r  <= in_ch.char_code;
      nc_r  <= in_ch.new_col;
      nr_r  <= in_ch.new_row;
      dig_r <= {in_ch.number, (BCD_W - NUM_W)'(0)};
    end else if ((state_r == S_CONV) && conv_done) begin
      dig_r <= conv_bcd;
    end else if (skip || (fire && shift_dig)) begin
      dig_r <= {dig_r[BCD_W-5:0], 4'h0};
    end
  end

  // colour registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FG:  fg_r <= cfg_data;
        CFG_BG:  bg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_we_r    <= cmd.put;
      out_idx_r   <= cmd.put ? stat.idx : '0;
      out_entry_r <= cmd.put ? {bg_r, fg_r, emit_char} : '0;
      out_col_r   <= stat.col;
      out_row_r   <= stat.row;
      out_last_r  <= (cnt_r == CNT_W'(1));
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.write_enable   = out_we_r;
  assign out_ch.cell_index     = out_idx_r;
  assign out_ch.cell_entry     = out_entry_r;
  assign out_ch.cursor_col_now = out_col_r;
  assign out_ch.cursor_row_now = out_row_r;
  assign out_ch.last           = out_last_r;

  `TCW_ASSERT_NXT(a_one_at_a_time, accept, !in_ch.ready)
  `TCW_ASSERT_IMP(a_nowrite_zero, out_valid_r && !out_we_r, (out_idx_r == '0) && (out_entry_r == '0))
  `TCW_ASSERT(a_state_legal, (state_r == S_IDLE) || (state_r == S_CONV) || (state_r == S_EMIT))

endmodule

### hw/rtl/tcw_bcd_conv.sv
// ----------------------------------------------------------------------------
// tcw_bcd_conv
// Binary to BCD, one shift-and-add-3 step per cycle.
// ----------------------------------------------------------------------------
module tcw_bcd_conv (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tcw_pkg::NUM_W-1:0]  value,
  output logic                       done,
  output logic [tcw_pkg::BCD_W-1:0]  bcd
);
  import tcw_pkg::*;

  logic [NUM_W-1:0]  sh_r;
  logic [BCD_W-1:0]  bcd_r, bcd_adj;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r, done_r;

  // add 3 to every digit of 5 or more, digits are independent
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= value;
      bcd_r <= '0;
    end else if (busy_r) begin
      {bcd_r, sh_r} <= {bcd_adj[BCD_W-2:0], sh_r, 1'b0};
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

### hw/rtl/tcw_cursor.sv
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor column/row with wrap, cell index of the current position.
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_defines.svh"

module tcw_cursor (
  input  logic                clk,
  input  logic                rst_n,
  input  tcw_pkg::cur_cmd_t   cmd,
  output tcw_pkg::cur_stat_t  stat
);
  import tcw_pkg::*;

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt, row_inc;
  logic             set_ok;

  assign row_inc = (row_r == ROW_LAST) ? '0 : row_r + 1'b1;
  assign set_ok  = (cmd.col < POS_W'(COLUMNS)) && (cmd.row < POS_W'(ROWS));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.set) begin
      if (set_ok) begin
        col_nxt = cmd.col[COL_W-1:0];
        row_nxt = cmd.row[ROW_W-1:0];
      end
    end else if (cmd.newline) begin
      col_nxt = '0;
      row_nxt = row_inc;
    end else if (cmd.put) begin
      if (col_r == COL_LAST) begin
        col_nxt = '0;
        row_nxt = row_inc;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign stat.col = col_nxt;
  assign stat.row = row_nxt;
  assign stat.idx = IDX_W'(row_r) * IDX_W'(COLUMNS) + IDX_W'(col_r);

  `TCW_ASSERT(a_col_range, col_r <= COL_LAST)
  `TCW_ASSERT(a_row_range, row_r <= ROW_LAST)
  `TCW_ASSERT_NXT(a_set_off_screen, cmd.set && !set_ok, $stable(col_r) && $stable(row_r))

endmodule

### tb/text_console_cell_writer_test.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_test
// Self-checking bench for the text console writer. Command words go in on
// a valid/ready channel with bursty pacing. A cursor and colour model in the
// bench builds the expected cell words. A checker compares every word the
// writer hands out, field by field, against the oldest expected word. The
// output sink stalls on its own pattern, with one long hold-off that backs
// the writer up into its command port.
// ----------------------------------------------------------------------------
module text_console_cell_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  // generous cap on the length of the whole run
  localparam int CYCLE_LIMIT   = 600000;
  // long sink hold-off used by the back-pressure test
  localparam int HOLD_CYCLES   = 300;
  // quiet cycles after the last expected word before colour writes or the end
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_WORDS   = 67;

  // one result word as the writer should present it
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] entry;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               last;
  } cell_word_t;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tcw_in_if  in_ch();
  tcw_out_if out_ch();

  text_console_cell_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Console model: cursor and colours as the writer should hold them, plus the
  // queue of cell words still owed by the writer.
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] model_col;
  logic [ROW_W-1:0] model_row;
  logic [CLR_W-1:0] text_fg;
  logic [CLR_W-1:0] text_bg;
  cell_word_t       expected_cells[$];

  int mismatches;
  int cycles;
  int burst_left;
  int hold_requests;

  // column back to 0, next row, wrap from the bottom row to the top (no scroll)
  function automatic void advance_row();
    model_col = '0;
    if (int'(model_row) + 1 >= ROWS) begin
      model_row = '0;
    end else begin
      model_row = model_row + 1'b1;
    end
  endfunction

  // one character through the put path: a cell write, or a bare cursor move
  // for newline
  function automatic void put_glyph(input logic [CHAR_W-1:0] ch, input logic last_word);
    cell_word_t w;
    w = '0;
    w.last = last_word;
    if (ch == CHAR_NEWLINE) begin
      advance_row();
    end else begin
      w.we    = 1'b1;
      w.idx   = IDX_W'(int'(model_row) * COLUMNS + int'(model_col));
      // attribute byte is background:foreground, character in the low byte
      w.entry = {text_bg, text_fg, ch};
      if (int'(model_col) + 1 >= COLUMNS) begin
        advance_row();
      end else begin
        model_col = model_col + 1'b1;
      end
    end
    w.col = model_col;
    w.row = model_row;
    expected_cells.push_back(w);
  endfunction

  // expected cell words for one accepted command word
  function automatic void predict_cells(input logic [1:0] op, input logic [CHAR_W-1:0] ch,
                                        input logic [NUM_W-1:0] num,
                                        input logic [POS_W-1:0] nc,
                                        input logic [POS_W-1:0] nr);
    int               digs[10];
    int               n;
    int               j;
    int               s;
    logic [NUM_W-1:0] v;
    logic [3:0]       d;
    cell_word_t       w;
    case (op)
      OP_PUT: begin
        put_glyph(ch, 1'b1);
      end
      OP_DEC: begin
        if (num == 0) begin
          put_glyph(CHAR_ZERO, 1'b1);
        end else begin
          // collect digits least significant first, emit from the top
          n = 0;
          v = num;
          while (v != 0) begin
            digs[n] = v % 10;
            v = v / 10;
            n++;
          end
          for (j = n - 1; j >= 0; j--) begin
            put_glyph(CHAR_ZERO + CHAR_W'(digs[j]), j == 0);
          end
        end
      end
      OP_HEX: begin
        put_glyph(CHAR_ZERO, 1'b0);
        put_glyph(CHAR_X, 1'b0);
        for (s = 7; s >= 0; s--) begin
          d = num[s*4 +: 4];
          put_glyph((d < 4'd10) ? CHAR_ZERO + d : CHAR_A + d - 8'd10, s == 0);
        end
      end
      default: begin
        // set cursor: off-screen requests leave the cursor alone
        if (nc < COLUMNS && nr < ROWS) begin
          model_col = nc[COL_W-1:0];
          model_row = nr[ROW_W-1:0];
        end
        w = '0;
        w.col  = model_col;
        w.row  = model_row;
        w.last = 1'b1;
        expected_cells.push_back(w);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle cap
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout, %0d words still owed", $time, expected_cells.size());
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sink pacing: runs of always-ready, random stalls, a fixed 2-of-5 stall
  // pattern and mostly-stalled stretches. A bump of hold_requests holds ready
  // low through the long hold-off, counted here.
  // ---------------------------------------------------------------------------
  initial begin : sink_pacing
    int mode;
    int mode_left;
    int phase;
    int hold_left;
    int hold_seen;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      phase = (phase + 1) % 5;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 2) != 0);
          2:       out_ch.ready <= (phase >= 2);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every word taken from the writer against the oldest expectation.
  // Sampled at the edge, so the writer's outputs are their pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : word_check
    cell_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("unexpected word, cell_index", 32'(out_ch.cell_index), '0);
      end else begin
        want = expected_cells.pop_front();
        if (out_ch.write_enable !== want.we)
          report_mismatch("write_enable", 32'(out_ch.write_enable), 32'(want.we));
        if (out_ch.cell_index !== want.idx)
          report_mismatch("cell_index", 32'(out_ch.cell_index), 32'(want.idx));
        if (out_ch.cell_entry !== want.entry)
          report_mismatch("cell_entry", 32'(out_ch.cell_entry), 32'(want.entry));
        if (out_ch.cursor_col_now !== want.col)
          report_mismatch("cursor_col_now", 32'(out_ch.cursor_col_now), 32'(want.col));
        if (out_ch.cursor_row_now !== want.row)
          report_mismatch("cursor_row_now", 32'(out_ch.cursor_row_now), 32'(want.row));
        if (out_ch.last !== want.last)
          report_mismatch("last", 32'(out_ch.last), 32'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Offer one command word and wait for it to be taken. Words go out in
  // bursts; between bursts valid drops for a random gap (sometimes none).
  // valid is never lowered at the edge a word is taken, so back-to-back
  // words keep it high without a second assignment in that step.
  task automatic send_command(input logic [1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [NUM_W-1:0] num, input logic [POS_W-1:0] nc,
                              input logic [POS_W-1:0] nr);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    end
    burst_left--;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.char_code <= ch;
    in_ch.number    <= num;
    in_ch.new_col   <= nc;
    in_ch.new_row   <= nr;
    do @(posedge clk); while (!in_ch.ready);
    predict_cells(op, ch, num, nc, nr);
  endtask

  // unused operand fields carry random junk so their bits toggle too
  task automatic put_char_word(input logic [CHAR_W-1:0] ch);
    send_command(OP_PUT, ch, $urandom, POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic number_word(input logic [1:0] op, input logic [NUM_W-1:0] num);
    send_command(op, CHAR_W'($urandom), num, POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic move_word(input logic [POS_W-1:0] nc, input logic [POS_W-1:0] nr);
    send_command(OP_SETCUR, CHAR_W'($urandom), $urandom, nc, nr);
  endtask

  // drop valid, let every owed word come out, then a few quiet cycles
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both colour registers, written back to back while the writer is idle
  task automatic set_colours(input logic [CLR_W-1:0] fg, input logic [CLR_W-1:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FG;
    cfg_data  <= fg;
    @(posedge clk);
    cfg_index <= CFG_BG;
    cfg_data  <= bg;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    text_fg = fg;
    text_bg = bg;
  endtask

  // one random command word, weighted toward put character
  task automatic send_random_word();
    int               pick;
    int unsigned      p;
    logic [1:0]       op;
    logic [CHAR_W-1:0] ch;
    logic [NUM_W-1:0] num;
    logic [POS_W-1:0] nc;
    logic [POS_W-1:0] nr;
    ch   = CHAR_W'($urandom);
    num  = $urandom;
    nc   = POS_W'($urandom);
    nr   = POS_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      op = OP_PUT;
      if ($urandom_range(0, 6) == 0) ch = CHAR_NEWLINE;
    end else if (pick < 65) begin
      op = OP_DEC;
      case ($urandom_range(0, 3))
        0: num = $urandom;
        1: num = $urandom >> $urandom_range(0, 31);   // spread of digit counts
        2: num = $urandom_range(0, 99);
        default: begin
          // powers of ten and one below: digit-count boundaries
          p = 1;
          repeat ($urandom_range(0, 9)) p = p * 10;
          num = $urandom_range(0, 1) ? p : p - 1;
        end
      endcase
    end else if (pick < 80) begin
      op = OP_HEX;
    end else begin
      op = OP_SETCUR;
      // mostly on-screen moves, the rest anywhere in the 8-bit range
      if ($urandom_range(0, 9) < 7) begin
        nc = POS_W'($urandom_range(0, COLUMNS - 1));
        nr = POS_W'($urandom_range(0, ROWS - 1));
      end
    end
    send_command(op, ch, num, nc, nr);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // character extremes, a high-bit byte (must not sign-extend), newline
  task automatic test_put_chars();
    put_char_word(8'h00);
    put_char_word(8'hFF);
    put_char_word(8'h80);
    put_char_word(CHAR_A);
    put_char_word(CHAR_NEWLINE);
    put_char_word(8'h7F);
  endtask

  // zero prints one '0', no leading zeros otherwise, full ten digits at max
  task automatic test_decimal();
    number_word(OP_DEC, 32'd0);
    number_word(OP_DEC, 32'd1);
    number_word(OP_DEC, 32'd9);
    number_word(OP_DEC, 32'd10);
    number_word(OP_DEC, 32'd1000000000);
    number_word(OP_DEC, 32'hFFFF_FFFF);
  endtask

  // '0x' plus eight digits always, letters uppercase
  task automatic test_hex();
    number_word(OP_HEX, 32'h0000_0000);
    number_word(OP_HEX, 32'hFFFF_FFFF);
    number_word(OP_HEX, 32'h0123_ABCD);
    number_word(OP_HEX, 32'h4567_89EF);
  endtask

  // bottom-right corner wrap, off-screen requests ignored, newline on the
  // last row wraps to the top
  task automatic test_cursor_moves();
    move_word(POS_W'(COLUMNS - 1), POS_W'(ROWS - 1));
    put_char_word(8'h5A);
    move_word(POS_W'(COLUMNS), 8'd0);
    move_word(8'd0, POS_W'(ROWS));
    move_word(8'hFF, 8'hFF);
    move_word(8'd5, POS_W'(ROWS - 1));
    put_char_word(CHAR_NEWLINE);
    move_word(8'd0, 8'd0);
  endtask

  // sink holds off for a long stretch while commands keep coming: the writer
  // fills its output register and stops taking command words
  task automatic test_backpressure();
    hold_requests++;
    repeat (10) send_random_word();
  endtask

  // random traffic under several colour settings, extremes first
  task automatic test_random_phases();
    logic [CLR_W-1:0] fg_set[RANDOM_PHASES];
    logic [CLR_W-1:0] bg_set[RANDOM_PHASES];
    int               ph;
    fg_set = '{4'h0, 4'hF, 4'h0, 4'hF, 4'h0};
    bg_set = '{4'h0, 4'hF, 4'hF, 4'h0, 4'h0};
    fg_set[RANDOM_PHASES-1] = CLR_W'($urandom);
    bg_set[RANDOM_PHASES-1] = CLR_W'($urandom);
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      set_colours(fg_set[ph], bg_set[ph]);
      repeat (PHASE_WORDS) send_random_word();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatches    = 0;
    burst_left    = 0;
    hold_requests = 0;
    model_col     = '0;
    model_row     = '0;
    text_fg       = FG_RESET;
    text_bg       = BG_RESET;

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_FG;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_PUT;
    in_ch.char_code <= '0;
    in_ch.number    <= '0;
    in_ch.new_col   <= '0;
    in_ch.new_row   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs with the reset colours
    test_put_chars();
    test_decimal();
    test_hex();
    test_cursor_moves();
    test_backpressure();
    test_random_phases();
    wait_idle();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
